/* hdl/cdq_pkg.sv */
// Package with the types and constants of the circular double-ended queue.
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned DATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(DEPTH);
  localparam logic [DATA_W-1:0] NONE_VALUE = '1;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_REAR  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_REAR   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_REAR  = 3'd5
  } func_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic               is_empty;
    logic               is_full;
  } out_word_t;

endpackage

`default_nettype wire

/* hdl/circular_double_ended_queue_top.sv */
// Top level of the circular double-ended queue with its store and result registers.
`default_nettype none

// The queue takes one word per cycle while in_stall_o is low and answers each with
// one result word, passed through the registered read port of the element store and
// then the output register. Pointers, count and store are updated at the edge that
// accepts the word, so consecutive operations see each other's effects without any
// bubble. A write of the capacity register empties the queue. A capacity of 0 acts
// as 1 and one above the store depth acts as the depth. Store entries are never
// returned before being written, so the store has no reset and no clearing pass.
module circular_double_ended_queue_top
  import cdq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_word_t         in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_word_t             out_word_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  logic [CAP_W-1:0]  capacity_q;
  logic [CAP_W-1:0]  cap_use;
  logic [ADDR_W-1:0] cap_m1;
  logic [ADDR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CAP_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              mem_we, ok, use_mem, in_accept, s1_adv;
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] mem_rdata_q;
  logic              s1_valid_q, s1_ok_q, s1_use_mem_q, s1_empty_q, s1_full_q;
  logic              out_valid_q;
  out_word_t         out_q;

  always_comb begin
    if (capacity_q == '0) begin
      cap_use = CAP_W'(1);
    end else if (capacity_q > CAP_W'(DEPTH)) begin
      cap_use = CAP_W'(DEPTH);
    end else begin
      cap_use = capacity_q;
    end
  end
  assign cap_m1 = ADDR_W'(cap_use - CAP_W'(1));

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    wr_addr = '0;
    rd_addr = head_q;
    mem_we  = 1'b0;
    ok      = 1'b0;
    use_mem = 1'b0;
    unique case (in_word_i.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
        if (count_q < cap_use) begin
          if (count_q == '0) begin
            head_d  = '0;
            tail_d  = '0;
            wr_addr = '0;
          end else if (in_word_i.func == FUNC_PUSH_FRONT) begin
            head_d  = (head_q == '0) ? cap_m1 : head_q - ADDR_W'(1);
            wr_addr = head_d;
          end else begin
            tail_d  = (({1'b0, tail_q} + CAP_W'(1)) >= cap_use) ? '0 : tail_q + ADDR_W'(1);
            wr_addr = tail_d;
          end
          mem_we  = 1'b1;
          count_d = count_q + CAP_W'(1);
          ok      = 1'b1;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_REAR: begin
        if (count_q != '0) begin
          rd_addr = (in_word_i.func == FUNC_POP_FRONT) ? head_q : tail_q;
          use_mem = 1'b1;
          ok      = 1'b1;
          count_d = count_q - CAP_W'(1);
          if (count_d == '0) begin
            head_d = '0;
            tail_d = '0;
          end else if (in_word_i.func == FUNC_POP_FRONT) begin
            head_d = (({1'b0, head_q} + CAP_W'(1)) >= cap_use) ? '0 : head_q + ADDR_W'(1);
          end else begin
            tail_d = (tail_q == '0) ? cap_m1 : tail_q - ADDR_W'(1);
          end
        end
      end
      FUNC_PEEK_FRONT, FUNC_PEEK_REAR: begin
        if (count_q != '0) begin
          rd_addr = (in_word_i.func == FUNC_PEEK_FRONT) ? head_q : tail_q;
          use_mem = 1'b1;
          ok      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else if (in_accept) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && mem_we) begin
      mem_q[wr_addr] <= in_word_i.push_value;
    end
    if (in_accept) begin
      mem_rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ok_q      <= ok;
      s1_use_mem_q <= use_mem;
      s1_empty_q   <= (count_d == '0);
      s1_full_q    <= (count_d >= cap_use);
    end
    if (s1_adv) begin
      out_q.ok         <= s1_ok_q;
      out_q.read_value <= s1_use_mem_q ? mem_rdata_q : NONE_VALUE;
      out_q.is_empty   <= s1_empty_q;
      out_q.is_full    <= s1_full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_use)
    else $error("element count exceeds capacity in use");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with pointers away from entry 0");

  a_fail_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.ok) |-> (out_word_o.read_value == NONE_VALUE))
    else $error("failed operation returned a value other than all ones");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.is_empty && out_word_o.is_full))
    else $error("result word reports both empty and full");

endmodule

`default_nettype wire
